// ===== design/bgtr_pkg.sv =====
package bgtr_pkg;

   localparam int unsigned POSITION_WIDTH_DEFAULT = 31;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic REG_SCALE_MODE = 1'b0;

   typedef enum logic [2:0] {
      MODE_DOUBLE        = 3'd0,
      MODE_HALVE         = 3'd1,
      MODE_TWO_THIRDS    = 3'd2,
      MODE_THREE_FOURTHS = 3'd3,
      MODE_FOUR_THIRDS   = 3'd4,
      MODE_THREE_HALVES  = 3'd5
   } mode_type;

   function automatic logic [2:0] mode_k(input logic [2:0] mode);
      logic [2:0] k;
      case (mode)
         MODE_DOUBLE:        k = 3'd2;
         MODE_HALVE:         k = 3'd1;
         MODE_TWO_THIRDS:    k = 3'd2;
         MODE_THREE_FOURTHS: k = 3'd3;
         MODE_FOUR_THIRDS:   k = 3'd4;
         MODE_THREE_HALVES:  k = 3'd3;
         default:            k = 3'd1;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] mode_m(input logic [2:0] mode);
      logic [2:0] m;
      case (mode)
         MODE_DOUBLE:        m = 3'd1;
         MODE_HALVE:         m = 3'd2;
         MODE_TWO_THIRDS:    m = 3'd3;
         MODE_THREE_FOURTHS: m = 3'd4;
         MODE_FOUR_THIRDS:   m = 3'd3;
         MODE_THREE_HALVES:  m = 3'd2;
         default:            m = 3'd1;
      endcase
      return m;
   endfunction

   // floor(r*s/k) for a remainder r below k and a slot s below k
   function automatic logic [1:0] frac_step(input logic [1:0] r, input logic [1:0] s,
                                            input logic [2:0] k);
      logic [3:0] prod;
      logic [1:0] f;
      prod = {2'b00, r} * {2'b00, s};
      case (k)
         3'd2:    f = prod[2:1];
         3'd3:    f = (prod >= 4'd6) ? 2'd2 : ((prod >= 4'd3) ? 2'd1 : 2'd0);
         3'd4:    f = prod[3:2];
         default: f = 2'd0;
      endcase
      return f;
   endfunction

endpackage

// ===== design/beat_grid_tempo_rescaler.sv =====
// Beat grid tempo rescaler.
// req_* stream: one beat position per word (tdata), tuser = start of a new beat list.
// rsp_* stream: kept beat positions of the rescaled grid (tdata), tlast on the final
// word caused by one request word; a request word may cause zero, one or two words.
// csr_* port: APB-style, register 0 (byte address 0) is scale_mode, 3 bits, reset 0;
// 0 double, 1 halve, 2 two thirds, 3 three fourths, 4 four thirds, 5 three halves.
// Write scale_mode only while the block is idle.
// Order: an accepted word is planned into the input register; its first result is
// loaded into the output register when that register next advances, which waits on
// rsp_tready while a word is held there; rsp_tvalid rises with a load that keeps a beat.
// Throughput: one request word per cycle while each causes at most one result and
// rsp_tready stays high; a word with two results holds the output register until both are taken.
// Reset clears the valid flags of the input and output registers, the beat history
// and scale_mode.
// When rsp_tready is low the output register holds its words, the input register
// holds its word and req_tready drops with them; no word is lost or repeated.
module beat_grid_tempo_rescaler
   import bgtr_pkg::*;
#(
   parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((POSITION_WIDTH+7)/8)*8-1:0]    req_tdata,  // beat_position
   input  logic                                   req_tuser,  // start_of_list
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((POSITION_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // out_position
   output logic                                   rsp_tlast,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]              csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned DataWidth = ((POSITION_WIDTH + 7) / 8) * 8;
   localparam int unsigned ProdWidth = 2 * POSITION_WIDTH + 2;
   // ceil(2^(W+1)/3): the top bits of gap times this give gap/3 for any W-bit gap
   localparam logic [ProdWidth-1:0] Recip3 =
      ((ProdWidth'(1) << (POSITION_WIDTH + 1)) + ProdWidth'(2)) / ProdWidth'(3);

   typedef struct packed {
      logic [POSITION_WIDTH-1:0] gap;
      logic [POSITION_WIDTH-1:0] pos;
      logic [POSITION_WIDTH-1:0] prev;
      logic [1:0]                cnt;
      logic [2:0]                k;
      logic [2:0]                sel0;
      logic [2:0]                sel1;
   } pipe_type;

   logic [2:0]                mode_ff;
   logic [POSITION_WIDTH-1:0] prev_ff;
   logic                      have_ff;
   logic [1:0]                phase_ff;
   logic [1:0]                phase_in;

   pipe_type                  pipe_ff;
   pipe_type                  pipe_in;
   logic                      pipe_vld_ff;

   logic [1:0]                emit_cnt_ff;
   logic [POSITION_WIDTH-1:0] emit_pos0_ff;
   logic [POSITION_WIDTH-1:0] emit_pos1_ff;
   logic [POSITION_WIDTH-1:0] emit_pos0_in;
   logic [POSITION_WIDTH-1:0] emit_pos1_in;

   logic                      move;
   logic                      accept;
   logic                      rsp_take;
   logic                      csr_write;
   logic [POSITION_WIDTH-1:0] req_pos;

   assign req_pos    = req_tdata[POSITION_WIDTH-1:0];
   assign move       = (emit_cnt_ff == 2'd0) || ((emit_cnt_ff == 2'd1) && rsp_tready);
   assign req_tready = move;
   assign accept     = req_tvalid && move;
   assign rsp_tvalid = (emit_cnt_ff != 2'd0);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = DataWidth'(emit_pos0_ff);
   assign rsp_tlast  = (emit_cnt_ff == 2'd1);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_SCALE_MODE) ? {29'd0, mode_ff} : 32'd0;

   // plan which expanded beats are kept
   always_comb begin
      logic [2:0] k;
      logic [2:0] m;
      logic [1:0] ph;
      logic [2:0] ph_inc;
      logic [1:0] cnt;
      logic       keep;
      logic       start;
      pipe_type   entry;
      k     = mode_k(mode_ff);
      m     = mode_m(mode_ff);
      start = req_tuser || !have_ff;
      entry      = '0;
      entry.pos  = req_pos;
      entry.prev = prev_ff;
      entry.gap  = (req_pos >= prev_ff) ? (req_pos - prev_ff) : '0;
      entry.k    = k;
      ph   = phase_ff;
      cnt  = 2'd0;
      keep = 1'b0;
      ph_inc = 3'd0;
      if (start) begin
         entry.cnt  = 2'd1;
         entry.sel0 = k;
         ph = (m <= 3'd1) ? 2'd0 : 2'd1;
      end else begin
         for (int s = 1; s <= 4; s++) begin
            if (3'(s) <= k) begin
               keep   = (ph == 2'd0);
               ph_inc = {1'b0, ph} + 3'd1;
               ph     = (ph_inc >= m) ? 2'd0 : ph_inc[1:0];
               if (keep) begin
                  if (cnt == 2'd0) begin
                     entry.sel0 = 3'(s);
                  end else if (cnt == 2'd1) begin
                     entry.sel1 = 3'(s);
                  end
                  if (cnt != 2'd2) begin
                     cnt = cnt + 2'd1;
                  end
               end
            end
         end
         entry.cnt = cnt;
      end
      phase_in = ph;
      pipe_in  = entry;
   end

   // split the gap into k slots and form the kept positions
   always_comb begin
      logic [ProdWidth-1:0]      prod3;
      logic [POSITION_WIDTH-1:0] q3;
      logic [POSITION_WIDTH-1:0] q;
      logic [POSITION_WIDTH-1:0] qi0;
      logic [POSITION_WIDTH-1:0] qi1;
      logic [1:0]                r;
      logic [1:0]                frac0;
      logic [1:0]                frac1;
      prod3 = ProdWidth'(pipe_ff.gap) * Recip3;
      q3    = prod3[POSITION_WIDTH+1 +: POSITION_WIDTH];
      case (pipe_ff.k)
         3'd2: begin
            q = pipe_ff.gap >> 1;
            r = {1'b0, pipe_ff.gap[0]};
         end
         3'd3: begin
            q = q3;
            r = pipe_ff.gap[1:0] - q3[1:0] - {q3[0], 1'b0};
         end
         3'd4: begin
            q = pipe_ff.gap >> 2;
            r = pipe_ff.gap[1:0];
         end
         default: begin
            q = pipe_ff.gap;
            r = 2'd0;
         end
      endcase
      case (pipe_ff.sel0)
         3'd2:    qi0 = q << 1;
         3'd3:    qi0 = q + (q << 1);
         default: qi0 = q;
      endcase
      case (pipe_ff.sel1)
         3'd2:    qi1 = q << 1;
         3'd3:    qi1 = q + (q << 1);
         default: qi1 = q;
      endcase
      frac0 = frac_step(r, pipe_ff.sel0[1:0], pipe_ff.k);
      frac1 = frac_step(r, pipe_ff.sel1[1:0], pipe_ff.k);
      emit_pos0_in = (pipe_ff.sel0 == pipe_ff.k) ? pipe_ff.pos :
                     (pipe_ff.prev + qi0 + POSITION_WIDTH'(frac0));
      emit_pos1_in = (pipe_ff.sel1 == pipe_ff.k) ? pipe_ff.pos :
                     (pipe_ff.prev + qi1 + POSITION_WIDTH'(frac1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 3'd0;
         prev_ff     <= '0;
         have_ff     <= 1'b0;
         phase_ff    <= 2'd0;
         pipe_vld_ff <= 1'b0;
         emit_cnt_ff <= 2'd0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_SCALE_MODE)) begin
            mode_ff <= csr_pwdata[2:0];
         end
         if (accept) begin
            prev_ff  <= req_pos;
            have_ff  <= 1'b1;
            phase_ff <= phase_in;
         end
         if (move) begin
            pipe_vld_ff <= accept;
            emit_cnt_ff <= pipe_vld_ff ? pipe_ff.cnt : 2'd0;
         end else if (rsp_take) begin
            emit_cnt_ff <= emit_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         pipe_ff      <= pipe_in;
         emit_pos0_ff <= emit_pos0_in;
         emit_pos1_ff <= emit_pos1_in;
      end else if (rsp_take) begin
         emit_pos0_ff <= emit_pos1_ff;
      end
   end

endmodule

// ===== tb/sv/beat_grid_tempo_rescaler_checker.sv =====
module beat_grid_tempo_rescaler_checker
   import bgtr_pkg::*;
#(
   parameter int unsigned POS_W  = POSITION_WIDTH_DEFAULT,
   parameter int unsigned DATA_W = ((POS_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [DATA_W-1:0]         req_tdata,   // beat_position
   input  logic                      req_tuser,   // start_of_list
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [DATA_W-1:0]         rsp_tdata,   // out_position
   input  logic                      rsp_tlast,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   input  logic                      csr_pready,
   output int                        error_count,
   output int                        open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_WIDTH-1:0] SCALE_MODE_ADDR = {REG_SCALE_MODE, 2'b00};

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last;
   } grid_word_type;

   grid_word_type    grid_queue[$];
   logic [2:0]       tempo_mode;
   logic [POS_W-1:0] prev_beat;
   logic             prev_valid;
   int unsigned      keep_phase;

   function automatic logic take_beat(input int unsigned m);
      logic keep;
      keep = (keep_phase == 0);
      if (keep_phase + 1 >= m)
         keep_phase = 0;
      else
         keep_phase = keep_phase + 1;
      return keep;
   endfunction

   task automatic push_grid_word(input logic [POS_W-1:0] position, input logic last);
      grid_word_type word;
      word.position = position;
      word.last     = last;
      grid_queue.push_back(word);
   endtask

   task automatic rescale_beat(input logic [POS_W-1:0] pos, input logic start);
      int unsigned k;
      int unsigned m;
      int unsigned n;
      int unsigned slot;
      logic [63:0] gap;
      logic [63:0] quot;
      logic [63:0] rem;
      logic [63:0] spot;
      case (tempo_mode)
         MODE_DOUBLE:        begin k = 2; m = 1; end
         MODE_HALVE:         begin k = 1; m = 2; end
         MODE_TWO_THIRDS:    begin k = 2; m = 3; end
         MODE_THREE_FOURTHS: begin k = 3; m = 4; end
         MODE_FOUR_THIRDS:   begin k = 4; m = 3; end
         MODE_THREE_HALVES:  begin k = 3; m = 2; end
         default:            begin k = 1; m = 1; end
      endcase
      if (start || !prev_valid) begin
         keep_phase = 0;
         void'(take_beat(m));
         prev_beat  = pos;
         prev_valid = 1'b1;
         push_grid_word(pos, 1'b1);
         return;
      end
      n    = 0;
      gap  = (pos >= prev_beat) ? (64'(pos) - 64'(prev_beat)) : 64'd0;
      quot = gap / 64'(k);
      rem  = gap % 64'(k);
      for (slot = 1; slot < k; slot++) begin
         spot = 64'(prev_beat) + quot * 64'(slot) + (rem * 64'(slot)) / 64'(k);
         if (take_beat(m) && n < 2) begin
            push_grid_word(spot[POS_W-1:0], 1'b0);
            n++;
         end
      end
      if (take_beat(m) && n < 2) begin
         push_grid_word(pos, 1'b0);
         n++;
      end
      prev_beat = pos;
      if (n > 0)
         grid_queue[grid_queue.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin : watch
      grid_word_type want;
      if (reset) begin
         grid_queue.delete();
         tempo_mode  = MODE_DOUBLE;
         prev_beat   = '0;
         prev_valid  = 1'b0;
         keep_phase  = 0;
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grid_queue.size() == 0) begin
               $error("unexpected word: out_position %0d, last_of_run %0b",
                      rsp_tdata[POS_W-1:0], rsp_tlast);
               error_count++;
            end else begin
               want = grid_queue.pop_front();
               if (rsp_tdata[POS_W-1:0] !== want.position) begin
                  $error("out_position: expected %0d, actual %0d",
                         want.position, rsp_tdata[POS_W-1:0]);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            rescale_beat(req_tdata[POS_W-1:0], req_tuser);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == SCALE_MODE_ADDR)
            tempo_mode = csr_pwdata[2:0];
      end
      open_count = grid_queue.size();
   end

endmodule

// ===== tb/sv/beat_grid_tempo_rescaler_tb.sv =====
module beat_grid_tempo_rescaler_tb;
   import bgtr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POS_W  = POSITION_WIDTH_DEFAULT;
   localparam int unsigned DATA_W = ((POS_W + 7) / 8) * 8;
   localparam logic [CSR_ADDR_WIDTH-1:0] SCALE_MODE_ADDR = {REG_SCALE_MODE, 2'b00};
   localparam logic [2:0] MODE_UNUSED_LOW  = 3'd6;
   localparam logic [2:0] MODE_UNUSED_HIGH = 3'd7;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int unsigned PHASE_COUNT = 14;
   localparam int unsigned PHASE_WORDS = 125;
   localparam int unsigned DRAIN_CYCLES = 12;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_W-1:0]         req_tdata = '0;   // beat_position
   logic                      req_tuser = 1'b0; // start_of_list
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [DATA_W-1:0]         rsp_tdata;        // out_position
   logic                      rsp_tlast;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   int                        error_count;
   int                        open_count;
   logic                      idle_on = 1'b1;
   logic                      stall_request = 1'b0;
   logic [POS_W-1:0]          cursor = '0;

   always #10 clock = ~clock;

   beat_grid_tempo_rescaler #(
      .POSITION_WIDTH(POS_W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   beat_grid_tempo_rescaler_checker #(
      .POS_W(POS_W)
   ) u_grid_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .open_count  (open_count)
   );

   task automatic send_beat(input logic [POS_W-1:0] pos, input logic start);
      while (idle_on && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(pos);
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      cursor = pos;
   endtask

   task automatic write_scale_mode(input logic [2:0] mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SCALE_MODE_ADDR;
      csr_pwdata  <= 32'(mode);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drain the grid, then let the pipeline empty of words that yield nothing
   task automatic settle_grid();
      req_tvalid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_grid_phase(input int unsigned count);
      logic [POS_W-1:0] pos;
      logic             start;
      int unsigned      pick;
      int unsigned      n;
      for (n = 0; n < count; n++) begin
         pick  = $urandom_range(0, 99);
         start = 1'b0;
         if (pick < 5) begin
            start = 1'b1;
            pos   = POS_W'($urandom);
         end else if (pick < 12)
            pos = POS_W'($urandom);
         else if (pick < 17)
            pos = cursor - POS_W'($urandom_range(1, 2000));
         else if (pick < 40)
            pos = cursor + POS_W'($urandom_range(0, 7));
         else if (pick < 75)
            pos = cursor + POS_W'($urandom_range(8, 5000));
         else if (pick < 92)
            pos = cursor + POS_W'($urandom_range(5001, 1 << 20));
         else
            pos = cursor + POS_W'($urandom);
         send_beat(pos, start);
      end
   endtask

   initial begin : receiver
      int unsigned hold_cycles;
      logic        stall_taken;
      hold_cycles = 0;
      stall_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request && !stall_taken) begin
            stall_taken = 1'b1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
   end

   initial begin : stimulus
      logic [2:0]  mode_plan [8];
      int unsigned ph;
      int unsigned guard;
      mode_plan = '{MODE_DOUBLE, MODE_HALVE, MODE_TWO_THIRDS, MODE_THREE_FOURTHS,
                    MODE_FOUR_THIRDS, MODE_THREE_HALVES, MODE_UNUSED_LOW, MODE_UNUSED_HIGH};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(POS_W'(100), 1'b0);
      send_beat(POS_W'(200), 1'b0);
      send_beat(POS_W'(350), 1'b0);
      send_beat(POS_W'(340), 1'b0);
      send_beat(POS_W'(0), 1'b1);
      send_beat(POS_MAX, 1'b0);
      send_beat(POS_MAX, 1'b1);
      send_beat(POS_W'(0), 1'b0);
      send_beat(POS_W'(1), 1'b0);
      settle_grid();

      write_scale_mode(MODE_FOUR_THIRDS);
      send_beat(POS_W'(4), 1'b0);
      send_beat(POS_W'(7), 1'b0);
      send_beat(POS_W'(10), 1'b0);
      send_beat(POS_W'(13), 1'b0);
      send_beat(POS_MAX, 1'b0);
      settle_grid();

      write_scale_mode(MODE_THREE_FOURTHS);
      send_beat(POS_W'(5000), 1'b1);
      send_beat(POS_W'(5100), 1'b0);
      send_beat(POS_W'(5200), 1'b0);
      settle_grid();

      write_scale_mode(MODE_HALVE);
      send_beat(POS_W'(5300), 1'b0);
      send_beat(POS_W'(5400), 1'b0);
      settle_grid();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph < 8)
            write_scale_mode(mode_plan[ph]);
         else
            write_scale_mode(mode_plan[$urandom_range(0, 7)]);
         if (ph == 2)
            stall_request = 1'b1;
         idle_on = (ph != 5);
         run_grid_phase(PHASE_WORDS);
         settle_grid();
      end
      idle_on = 1'b1;

      guard = 0;
      while (open_count != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
      if (open_count != 0)
         $error("%0d expected words never arrived", open_count);
      if (error_count == 0 && open_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== beat_grid_tempo_rescaler.f =====
design/bgtr_pkg.sv
design/beat_grid_tempo_rescaler.sv
tb/sv/beat_grid_tempo_rescaler_checker.sv
tb/sv/beat_grid_tempo_rescaler_tb.sv
